FILE: sv/arp_pkg.sv
// arp_pkg: item, scan token and write command types for the arp cache table
// no dependencies; imported by arp_cell, arp_cache_table and the testbench
package arp_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  // request item
  typedef struct packed {
    logic             mode;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_in;
  } in_t;

  // response item
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_out;
  } out_t;

  // item operation codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_ADD    = 1'b1;

  // search token that walks down the chain of cells
  typedef struct packed {
    logic             active;
    logic [IP_W-1:0]  ip;
    logic             found;
    logic [MAC_W-1:0] mac;
    logic             empty_found;
  } tok_t;

  // which cell takes a write
  typedef enum logic [1:0] {
    WR_HIT,
    WR_EMPTY,
    WR_PTR
  } wr_sel_t;

  // write command broadcast to all cells
  typedef struct packed {
    logic             en;
    wr_sel_t          sel;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } wr_t;

  // control states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

FILE: sv/arp_cache_table.sv
// arp_cache_table: ipv4 to mac table built as a chain of ENTRIES cells
// a lookup passes the token register of every cell, then the result register, then the response register
// a new item is taken only in idle, after the token of the last one has walked the cell chain
// the response register lets the next item enter while a result waits
// reset clears all valid bits, the replacement pointer and all control state at once
module arp_cache_table import arp_pkg::*; #(
  parameter int ENTRIES = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  in_t  req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output out_t rsp
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t           state;
  state_t           state_next;
  in_t              item;
  logic             res_found;
  logic             res_empty;
  logic [MAC_W-1:0] res_mac;
  logic [IDX_W-1:0] ptr;
  logic [IDX_W-1:0] ptr_next;
  logic [IDX_W-1:0] ptr_bcast;
  logic             accept;
  logic             load_rsp;
  logic             finish_add;
  wr_t              wr;
  tok_t             tok [ENTRIES+1];

  assign accept = req_valid && !req_stall;

  // token injected into the head of the chain on accept
  always_comb begin
    tok[0].active      = accept;
    tok[0].ip          = req.ip_addr;
    tok[0].found       = 1'b0;
    tok[0].mac         = '0;
    tok[0].empty_found = 1'b0;
  end

  // chain of slot cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    arp_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .wr      (wr),
      .ptr     (ptr_bcast)
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (tok[ENTRIES].active) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (item.mode == MODE_ADD || !rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // advanced replacement pointer, wrapping at the table size
  assign ptr_next = (ptr == IDX_W'(ENTRIES - 1)) ? '0 : IDX_W'(ptr + 1'b1);

  // state outputs: stall, write command, response load
  always_comb begin
    req_stall  = (state != ST_IDLE);
    finish_add = (state == ST_FINISH) && (item.mode == MODE_ADD);
    load_rsp   = (state == ST_FINISH) && (item.mode == MODE_LOOKUP) &&
                 (!rsp_valid || !rsp_stall);
    wr.en      = finish_add;
    wr.ip      = item.ip_addr;
    wr.mac     = item.mac_in;
    if (res_found) begin
      wr.sel = WR_HIT;
    end else if (res_empty) begin
      wr.sel = WR_EMPTY;
    end else begin
      wr.sel = WR_PTR;
    end
    ptr_bcast = (wr.sel == WR_PTR) ? ptr_next : ptr;
  end

  // item capture and search result from the chain tail
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (state == ST_SCAN && tok[ENTRIES].active) begin
      res_found <= tok[ENTRIES].found;
      res_empty <= tok[ENTRIES].empty_found;
      res_mac   <= tok[ENTRIES].mac;
    end
  end

  // replacement pointer moves only when a full table replaces a slot
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if (finish_add && wr.sel == WR_PTR) begin
      ptr <= ptr_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.hit     <= res_found;
      rsp.mac_out <= res_mac;
    end
  end

`ifndef ASSERT_OFF
  // the token reaches the tail only while a scan is in progress
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok[ENTRIES].active |-> state == ST_SCAN)
    else $error("search token at chain tail outside scan");

  // a miss always carries a zero mac
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.hit |-> rsp.mac_out == '0)
    else $error("miss response with nonzero mac");

  // pointer moves only on a replacing add
  a_ptr_move: assert property (@(posedge clk) disable iff (rst)
    ptr != $past(ptr) |-> $past(finish_add) && !$past(res_found) && !$past(res_empty))
    else $error("replacement pointer moved without a replacement");

  // a finished lookup waits while the response register is stalled
  a_rsp_wait: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && item.mode == MODE_LOOKUP && rsp_valid && rsp_stall
    |=> state == ST_FINISH)
    else $error("lookup result dropped while response stalled");
`endif

endmodule

FILE: sv/arp_cell.sv
// arp_cell: one table slot; checks the passing search token and takes writes
// depends on arp_pkg
module arp_cell import arp_pkg::*; #(
  parameter int IDX_W = 3,
  parameter int IDX   = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tok_t             tok_in,
  output tok_t             tok_out,
  input  wr_t              wr,
  input  logic [IDX_W-1:0] ptr
);

  logic             valid;
  logic [IP_W-1:0]  ip;
  logic [MAC_W-1:0] mac;
  logic             sel_hit;
  logic             sel_empty;
  logic             hit_here;
  logic             empty_here;
  logic             wr_here;
  tok_t             tok_next;

  // first valid match and first empty slot along the chain
  always_comb begin
    hit_here   = tok_in.active && !tok_in.found && valid && (ip == tok_in.ip);
    empty_here = tok_in.active && !tok_in.empty_found && !valid;
    tok_next   = tok_in;
    if (hit_here) begin
      tok_next.found = 1'b1;
      tok_next.mac   = mac;
    end
    if (empty_here) begin
      tok_next.empty_found = 1'b1;
    end
  end

  // token register toward the next cell, slot selection flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
      sel_hit        <= 1'b0;
      sel_empty      <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.active) begin
        sel_hit   <= hit_here;
        sel_empty <= empty_here;
      end
    end
  end

  // decide whether this slot takes the broadcast write
  always_comb begin
    case (wr.sel)
      WR_HIT:   wr_here = wr.en && sel_hit;
      WR_EMPTY: wr_here = wr.en && sel_empty;
      WR_PTR:   wr_here = wr.en && (ptr == IDX_W'(IDX));
      default:  wr_here = 1'b0;
    endcase
  end

  // slot contents; an update of a present address keeps its ip
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_here) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      mac <= wr.mac;
      if (wr.sel != WR_HIT) begin
        ip <= wr.ip;
      end
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// testbench: lookup and add items into arp_cache_table, each lookup result checked
// against a behavioral model of the table kept here or a preset expected value; depends on arp_pkg, arp_cache_table
module testbench;
  import arp_pkg::*;

  localparam int ENTRIES      = 8;
  localparam int PTR_W        = $clog2(ENTRIES);
  localparam int POOL         = 12;
  localparam int RANDOM_ITEMS = 1225;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 600;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t known;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_t  req;
  logic rsp_valid;
  logic rsp_stall;
  out_t rsp;

  // model of the table contents
  logic             slot_valid [ENTRIES];
  logic [IP_W-1:0]  slot_ip    [ENTRIES];
  logic [MAC_W-1:0] slot_mac   [ENTRIES];
  logic [PTR_W-1:0] victim_ptr;

  out_t            lookup_results [$];
  row_t            directed       [$];
  logic [IP_W-1:0] ip_pool        [POOL];

  int errors     = 0;
  int n_lookups  = 0;
  int n_adds     = 0;
  int n_hits     = 0;
  int n_results  = 0;
  int n_replaced = 0;

  arp_cache_table #(.ENTRIES(ENTRIES)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before an item; every fourth stretch of 100 runs with no gaps
  function automatic int draw_gap(input int idx);
    if ((idx / 100) % 4 == 2) return 0;
    return $urandom_range(0, 9);
  endfunction

  // apply one item to the model; returns 1 with the lookup result in resp
  function automatic bit cache_apply(input in_t item, output out_t resp);
    int match;
    int free;
    match = -1;
    free  = -1;
    resp  = '0;
    // lowest-numbered matching slot and lowest empty slot
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_ip[i] == item.ip_addr) match = i;
      if (!slot_valid[i]) free = i;
    end
    if (item.mode == MODE_LOOKUP) begin
      if (match >= 0) begin
        resp.hit     = 1'b1;
        resp.mac_out = slot_mac[match];
      end
      return 1'b1;
    end
    // add: update in place, else fill empty, else advance pointer and replace
    if (match >= 0) begin
      slot_mac[match] = item.mac_in;
    end else begin
      if (free < 0) begin
        victim_ptr = PTR_W'((int'(victim_ptr) + 1) % ENTRIES);
        free       = int'(victim_ptr);
        n_replaced++;
      end
      slot_valid[free] = 1'b1;
      slot_ip[free]    = item.ip_addr;
      slot_mac[free]   = item.mac_in;
    end
    return 1'b0;
  endfunction

  function automatic void add_row(input logic mode, input logic [IP_W-1:0] ip,
                                  input logic [MAC_W-1:0] mac, input bit typed,
                                  input logic hit, input logic [MAC_W-1:0] mac_out);
    row_t r;
    r.item.mode      = mode;
    r.item.ip_addr   = ip;
    r.item.mac_in    = mac;
    r.typed          = typed;
    r.known.hit      = hit;
    r.known.mac_out  = mac_out;
    directed.push_back(r);
  endfunction

  // present one item, hold it until accepted, then update the model
  task automatic offer_item(input in_t item, input bit typed, input out_t known, input int idx);
    int   gap;
    out_t resp;
    gap = draw_gap(idx);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    if (item.mode == MODE_LOOKUP) n_lookups++;
    else n_adds++;
    if (cache_apply(item, resp)) lookup_results.push_back(typed ? known : resp);
  endtask

  // stimulus
  initial begin
    in_t             item;
    out_t            none;
    logic [63:0]     bits;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    none       = '0;
    victim_ptr = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_ip[i]    = '0;
      slot_mac[i]   = '0;
    end

    // directed: empty table, extreme addresses and macs, update, fill, replacement
    add_row(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 48'h0);
    add_row(MODE_ADD,    32'h0000_0000, 48'h0, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, 1'b1, 48'h0);
    add_row(MODE_ADD,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
    add_row(MODE_ADD,    32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
    for (int k = 1; k <= 6; k++)
      add_row(MODE_ADD, IP_W'(k), 48'h0A0B_0C0D_0E00 + MAC_W'(k), 1'b0, 1'b0, 48'h0);
    // table full: the first replacement lands in slot 1
    add_row(MODE_ADD,    32'h0000_0007, 48'h5555_AAAA_5555, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0007, 48'h0, 1'b0, 1'b0, 48'h0);
    add_row(MODE_ADD,    32'h0000_0008, 48'hAAAA_5555_AAAA, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0001, 48'h0, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0008, 48'h0, 1'b0, 1'b0, 48'h0);
    // mac_in is ignored on a lookup
    add_row(MODE_LOOKUP, 32'h0000_0005, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b0, 48'h0);
    // update on a full table leaves the pointer alone
    add_row(MODE_ADD,    32'h0000_0000, 48'h1234_5678_9ABC, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h0000_0000, 48'h0, 1'b0, 1'b0, 48'h0);
    add_row(MODE_LOOKUP, 32'h8000_0000, 48'h0, 1'b0, 1'b0, 48'h0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r])
      offer_item(directed[r].item, directed[r].typed, directed[r].known, r);

    // random: mostly a small address pool so hits, updates and replacements recur
    ip_pool[0] = 32'h0000_0000;
    ip_pool[1] = 32'hFFFF_FFFF;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 250 == 0) begin
        for (int p = 2; p < POOL; p++)
          if (k == 0 || $urandom_range(0, 1)) ip_pool[p] = $urandom;
      end
      // sender pause until the table has answered everything
      if (k == PAUSE_AT) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (lookup_results.size() != 0);
      end
      bits         = {$urandom, $urandom};
      item.mode    = ($urandom_range(0, 99) < 45) ? MODE_ADD : MODE_LOOKUP;
      item.ip_addr = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL - 1)]
                                                  : $urandom;
      item.mac_in  = bits[MAC_W-1:0];
      offer_item(item, 1'b0, none, k);
    end
    req_valid <= 1'b0;

    // drain, then give any stray result time to show
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);
    $display("covered %0d lookups (%0d hits) and %0d adds with %0d slot replacements",
             n_lookups, n_hits, n_adds, n_replaced);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // result side: random stall per item, one long hold to back the table up
  initial begin
    int   stall_left;
    bit   held;
    out_t want;
    stall_left = 0;
    held       = 1'b0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
        if (lookup_results.size() == 0) begin
          $error("unexpected result: hit %0d mac_out %h", rsp.hit, rsp.mac_out);
          errors++;
        end else begin
          want = lookup_results.pop_front();
          if (rsp.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
            errors++;
          end
          if (rsp.mac_out !== want.mac_out) begin
            $error("mac_out: expected %h, got %h", want.mac_out, rsp.mac_out);
            errors++;
          end
        end
        if (rsp.hit === 1'b1) n_hits++;
        n_results++;
        stall_left = draw_gap(n_results);
        if (n_results == HOLD_AT && !held) begin
          stall_left = LONG_HOLD;
          held       = 1'b1;
        end
      end
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left--;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/arp_pkg.sv
sv/arp_cell.sv
sv/arp_cache_table.sv
tb/testbench.sv
